// ===== hw/rtl/ngbl_pkg.sv =====
// shared types and constants for the n-gram backoff lookup
`default_nettype none
package ngbl_pkg;
    localparam int NODE_COUNT  = 65536;
    localparam int ARC_COUNT   = 262144;
    localparam int MAX_BACKOFF = 8;
    localparam int NODE_W = $clog2(NODE_COUNT);
    localparam int ARC_W  = $clog2(ARC_COUNT);
    localparam int LIM_W  = ARC_W + 1;
    localparam int BO_W   = $clog2(MAX_BACKOFF + 1);

    typedef enum logic [1:0] {
        REQ_ARC  = 2'd0,
        REQ_NODE = 2'd1,
        REQ_WALK = 2'd2,
        REQ_BAD  = 2'd3
    } t_req;

    localparam logic [1:0] ST_FOUND = 2'd0;
    localparam logic [1:0] ST_FINAL = 2'd1;
    localparam logic [1:0] ST_LIMIT = 2'd2;

    typedef struct packed {
        t_req               req;
        logic [ARC_W-1:0]   idx;
        logic [15:0]        sym;
        logic [15:0]        tgt;
        logic signed [31:0] esc;
        logic [LIM_W-1:0]   lim;
        logic [15:0]        node;
        logic signed [31:0] score;
    } t_cmd;

    function automatic logic signed [31:0] sat_add(logic signed [31:0] a,
                                                   logic signed [31:0] b);
        logic signed [32:0] s;
        s = {a[31], a} + {b[31], b};
        if (s[32] != s[31]) begin
            sat_add = s[32] ? 32'sh8000_0000 : 32'sh7fff_ffff;
        end else begin
            sat_add = s[31:0];
        end
    endfunction
endpackage
`default_nettype wire

// ===== hw/rtl/ngbl_ram.sv =====
// generic single write port ram with registered read
`default_nettype none
module ngbl_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 1024
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end
endmodule
`default_nettype wire

// ===== hw/rtl/ngbl_front.sv =====
// request intake, classification and two-entry command queue
`default_nettype none
module ngbl_front (
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire logic            i_valid,
    output logic                 o_ready,
    input  wire ngbl_pkg::t_cmd  i_cmd,
    output logic                 o_valid,
    input  wire logic            i_ready,
    output ngbl_pkg::t_cmd       o_cmd
);
    import ngbl_pkg::*;
    t_cmd       r_q [2];
    logic       r_wp, r_rp;
    logic [1:0] r_cnt;
    logic       push, pop, keep;

    // bad request types and out of range writes are dropped here
    always_comb begin
        keep = 1'b0;
        case (i_cmd.req)
            REQ_ARC:  keep = 1'b1;
            REQ_NODE: keep = (i_cmd.idx < ARC_W'(NODE_COUNT)) || (ARC_W <= NODE_W);
            REQ_WALK: keep = 1'b1;
            default:  keep = 1'b0;
        endcase
    end

    assign o_ready = (r_cnt != 2'd2);
    assign push    = i_valid && o_ready && keep;
    assign o_valid = (r_cnt != 2'd0);
    assign pop     = o_valid && i_ready;
    assign o_cmd   = r_q[r_rp];

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_q[r_wp] <= i_cmd;
        end
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (push) r_wp <= ~r_wp;
            if (pop)  r_rp <= ~r_rp;
            r_cnt <= r_cnt + 2'(push) - 2'(pop);
        end
    end
endmodule
`default_nettype wire

// ===== hw/rtl/ngbl_back.sv =====
// memory writes and backoff walk sequencer
`default_nettype none
module ngbl_back (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic [15:0]        i_final_node,
    input  wire logic               i_valid,
    output logic                    o_ready,
    input  wire ngbl_pkg::t_cmd     i_cmd,
    output logic                    o_valid,
    input  wire logic               i_ready,
    output logic [15:0]             o_end_node,
    output logic signed [31:0]      o_score_out,
    output logic [1:0]              o_status
);
    import ngbl_pkg::*;

    typedef enum logic [3:0] {
        S_IDLE, S_CHK, S_LIM0, S_LIM1, S_RANGE, S_SRCH, S_SRD, S_SCMP,
        S_HRD, S_HIT, S_BRD, S_BO, S_OUT
    } t_state;

    t_state             r_st;
    logic [15:0]        r_sym, r_node;
    logic signed [31:0] r_acc;
    logic [BO_W-1:0]    r_bo;
    logic [LIM_W-1:0]   r_lo, r_limit, r_cnt, r_step;
    logic [1:0]         r_stat;
    logic               r_ov;
    logic [NODE_W-1:0]  r_naddr;
    logic [ARC_W-1:0]   r_aaddr;

    logic arc_we, node_we;
    logic [15:0]        a_sym, a_tgt, n_tgt;
    logic signed [31:0] a_sc, n_sc;
    logic [LIM_W-1:0]   n_lim, lim_cl;

    assign o_ready = (r_st == S_IDLE) && !r_ov;
    assign arc_we  = o_ready && i_valid && (i_cmd.req == REQ_ARC);
    assign node_we = o_ready && i_valid && (i_cmd.req == REQ_NODE);

    ngbl_ram #(.WIDTH(16), .DEPTH(ARC_COUNT)) u_asym (.i_clk, .i_we(arc_we),
        .i_waddr(i_cmd.idx), .i_wdata(i_cmd.sym), .i_raddr(r_aaddr), .o_rdata(a_sym));
    ngbl_ram #(.WIDTH(16), .DEPTH(ARC_COUNT)) u_atgt (.i_clk, .i_we(arc_we),
        .i_waddr(i_cmd.idx), .i_wdata(i_cmd.tgt), .i_raddr(r_aaddr), .o_rdata(a_tgt));
    ngbl_ram #(.WIDTH(32), .DEPTH(ARC_COUNT)) u_asc (.i_clk, .i_we(arc_we),
        .i_waddr(i_cmd.idx), .i_wdata(i_cmd.esc), .i_raddr(r_aaddr), .o_rdata(a_sc));
    ngbl_ram #(.WIDTH(LIM_W), .DEPTH(NODE_COUNT)) u_nlim (.i_clk, .i_we(node_we),
        .i_waddr(i_cmd.idx[NODE_W-1:0]), .i_wdata(i_cmd.lim), .i_raddr(r_naddr),
        .o_rdata(n_lim));
    ngbl_ram #(.WIDTH(16), .DEPTH(NODE_COUNT)) u_ntgt (.i_clk, .i_we(node_we),
        .i_waddr(i_cmd.idx[NODE_W-1:0]), .i_wdata(i_cmd.tgt), .i_raddr(r_naddr),
        .o_rdata(n_tgt));
    ngbl_ram #(.WIDTH(32), .DEPTH(NODE_COUNT)) u_nsc (.i_clk, .i_we(node_we),
        .i_waddr(i_cmd.idx[NODE_W-1:0]), .i_wdata(i_cmd.esc), .i_raddr(r_naddr),
        .o_rdata(n_sc));

    assign lim_cl = (n_lim > LIM_W'(ARC_COUNT)) ? LIM_W'(ARC_COUNT) : n_lim;

    assign o_valid     = r_ov;
    assign o_end_node  = r_node;
    assign o_score_out = r_acc;
    assign o_status    = r_stat;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st <= S_IDLE;
            r_ov <= 1'b0;
        end else begin
            if (r_ov && i_ready) r_ov <= 1'b0;
            case (r_st)
                S_IDLE: begin
                    if (o_ready && i_valid && i_cmd.req == REQ_WALK) begin
                        r_sym  <= i_cmd.sym;
                        r_node <= i_cmd.node;
                        r_acc  <= i_cmd.score;
                        r_bo   <= '0;
                        r_st   <= S_CHK;
                    end
                end
                S_CHK: begin
                    r_naddr <= NODE_W'(r_node);
                    if (r_node == i_final_node) begin
                        r_stat <= ST_FINAL;
                        r_st   <= S_OUT;
                    end else begin
                        r_st <= S_LIM0;
                    end
                end
                S_LIM0: begin
                    r_naddr <= NODE_W'(r_node - 16'd1);
                    r_st    <= S_LIM1;
                end
                S_LIM1: begin
                    r_limit <= lim_cl;
                    r_st    <= S_RANGE;
                end
                S_RANGE: begin
                    // backoff entry of this node is read ahead of a miss
                    r_naddr <= NODE_W'(r_node);
                    r_lo  <= (r_node == 16'd0) ? '0 : lim_cl;
                    r_cnt <= r_limit - ((r_node == 16'd0) ? '0 : lim_cl);
                    if (r_limit == '0 || (r_node != 16'd0 && lim_cl >= r_limit)) begin
                        r_st <= S_BRD;
                    end else begin
                        r_st <= S_SRCH;
                    end
                end
                S_SRCH: begin
                    if (r_cnt == '0) begin
                        r_aaddr <= r_lo[ARC_W-1:0];
                        r_st    <= (r_lo < r_limit) ? S_HRD : S_BRD;
                    end else begin
                        r_step  <= r_cnt >> 1;
                        r_aaddr <= ARC_W'(r_lo + (r_cnt >> 1));
                        r_st    <= S_SRD;
                    end
                end
                S_SRD: r_st <= S_SCMP;
                S_SCMP: begin
                    if (a_sym < r_sym) begin
                        r_lo  <= r_lo + r_step + 1'b1;
                        r_cnt <= r_cnt - r_step - 1'b1;
                    end else begin
                        r_cnt <= r_step;
                    end
                    r_st <= S_SRCH;
                end
                S_HRD: r_st <= S_HIT;
                S_HIT: begin
                    if (a_sym == r_sym) begin
                        r_acc  <= sat_add(r_acc, a_sc);
                        r_node <= a_tgt;
                        r_stat <= ST_FOUND;
                        r_st   <= S_OUT;
                    end else begin
                        r_st <= S_BRD;
                    end
                end
                S_BRD: begin
                    r_naddr <= NODE_W'(r_node);
                    if (r_bo >= BO_W'(MAX_BACKOFF)) begin
                        r_stat <= ST_LIMIT;
                        r_st   <= S_OUT;
                    end else begin
                        r_st <= S_BO;
                    end
                end
                S_BO: begin
                    r_bo   <= r_bo + 1'b1;
                    r_acc  <= sat_add(r_acc, n_sc);
                    r_node <= n_tgt;
                    r_st   <= S_CHK;
                end
                S_OUT: begin
                    if (!r_ov || i_ready) begin
                        r_ov <= 1'b1;
                        r_st <= S_IDLE;
                    end
                end
                default: r_st <= S_IDLE;
            endcase
        end
    end
endmodule
`default_nettype wire

// ===== hw/rtl/ngram_backoff_lookup_top.sv =====
// top level of the n-gram backoff lookup
// usage:
//   requests enter on i_valid/o_ready with one port per field; i_req_type
//   selects arc write, node write or walk. writes give no result, walks give
//   one result on o_valid/i_ready (end node, saturated score, status).
//   a front queue of two requests decouples intake from the walk engine,
//   which owns all six tables as rams with one write port and registered reads.
//   a write is taken by the engine while it is idle. a walk checks each node
//   against the final node, reads its arc range from the node limits and
//   bisects that range for the symbol; on a miss it backs off along the
//   node's backoff entry, and it stops on a hit, at the final node or at
//   the backoff limit.
//   i_cfg_we writes the final node register; write it while idle.
//   reset (synchronous, active low) empties the queue and the result register
//   and sets the final node to 0; table contents are kept but must be
//   written before they are read.
//   while the receiver stalls the result is held and the engine waits with
//   the next walk; the queue keeps taking requests until it is full.
`default_nettype none
module ngram_backoff_lookup_top (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_cfg_we,
    input  wire logic [15:0] i_cfg_wdata,
    input  wire logic        i_valid,
    output logic             o_ready,
    input  wire logic [1:0]  i_req_type,
    input  wire logic [17:0] i_entry_index,
    input  wire logic [15:0] i_symbol,
    input  wire logic [15:0] i_target_node,
    input  wire logic signed [31:0] i_entry_score,
    input  wire logic [18:0] i_arc_limit,
    input  wire logic [15:0] i_start_node,
    input  wire logic signed [31:0] i_score_in,
    output logic             o_valid,
    input  wire logic        i_ready,
    output logic [15:0]      o_end_node,
    output logic signed [31:0] o_score_out,
    output logic [1:0]       o_status
);
    import ngbl_pkg::*;
    logic [15:0] r_final;
    t_cmd in_cmd, q_cmd;
    logic q_valid, q_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_final <= '0;
        end else if (i_cfg_we) begin
            r_final <= i_cfg_wdata;
        end
    end

    assign in_cmd.req   = t_req'(i_req_type);
    assign in_cmd.idx   = ARC_W'(i_entry_index);
    assign in_cmd.sym   = i_symbol;
    assign in_cmd.tgt   = i_target_node;
    assign in_cmd.esc   = i_entry_score;
    assign in_cmd.lim   = LIM_W'(i_arc_limit);
    assign in_cmd.node  = i_start_node;
    assign in_cmd.score = i_score_in;

    ngbl_front u_front (.i_clk, .i_rst_n, .i_valid, .o_ready, .i_cmd(in_cmd),
        .o_valid(q_valid), .i_ready(q_ready), .o_cmd(q_cmd));

    ngbl_back u_back (.i_clk, .i_rst_n, .i_final_node(r_final), .i_valid(q_valid),
        .o_ready(q_ready), .i_cmd(q_cmd), .o_valid, .i_ready, .o_end_node,
        .o_score_out, .o_status);
endmodule
`default_nettype wire
